@@ design/toaluf_pkg.sv @@
// Shared types and constants for the two-operand ALU with status flags.
package toaluf_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 24;

  localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;
  localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

  // Flag tables, indexed by {src sign, dest sign, result sign}.
  localparam logic [7:0] CARRY_TAB = 8'hD4;
  localparam logic [7:0] OVF_TAB   = 8'h42;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_CMP = 3'd1,
    OP_XOR = 3'd2,
    OP_AND = 3'd3,
    OP_OR  = 3'd4,
    OP_BIT = 3'd5,
    OP_BIS = 3'd6,
    OP_BIC = 3'd7
  } op_t;

  typedef struct packed {
    logic ovf;
    logic neg;
    logic zero;
    logic carry;
  } flags_t;

  typedef struct packed {
    logic        byte_mode;
    logic        carry_in;
    logic [15:0] source_value;
    logic [15:0] dest_value;
    op_t         cmd;
  } item_t;

endpackage

@@ design/two_operand_alu_with_flags.sv @@
// Top level: registered 16-bit ALU with a kept carry/zero/negative/overflow word.
// Stages: input register, then result register; a stalled result stream holds
//   the item in the input register. Throughput: one item per cycle unless
//   m_tready stalls; the flag register is read and written by the same execute
//   step, so back-to-back items see each other's flags in order.
// Reset (rst, synchronous, active high) empties both stages and clears all flags.
module two_operand_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] cmd, [18:3] dest_value, [34:19] source_value, [35] carry_in,
  // [36] byte_mode, [39:37] zero
  input  logic [39:0] s_tdata,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] result_value, [16] carry_flag, [17] zero_flag, [18] negative_flag,
  // [19] overflow_flag, [23:20] zero
  output logic [23:0] m_tdata
);

  // Input register stage
  logic               in_valid;
  toaluf_pkg::item_t  in_item;

  // Kept status word
  toaluf_pkg::flags_t flags;
  toaluf_pkg::flags_t flags_next;

  // Result register stage
  logic [15:0]        out_result;
  toaluf_pkg::flags_t out_flags;

  logic [15:0]        exec_result;
  logic               out_free;
  logic               exec_go;

  // Result register can load when empty or draining this cycle
  assign out_free = !m_tvalid || m_tready;
  assign exec_go  = in_valid && out_free;
  assign s_tready = !in_valid || exec_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload only loads on a transfer; no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd          <= toaluf_pkg::op_t'(s_tdata[2:0]);
      in_item.dest_value   <= s_tdata[18:3];
      in_item.source_value <= s_tdata[34:19];
      in_item.carry_in     <= s_tdata[35];
      in_item.byte_mode    <= s_tdata[36];
    end
  end

  toaluf_exec u_exec (
    .item         (in_item),
    .flags        (flags),
    .result_value (exec_result),
    .flags_next   (flags_next)
  );

  // Flags update in place as each item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (exec_go) begin
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_result <= exec_result;
      out_flags  <= flags_next;
    end
  end

  assign m_tdata = {4'd0, out_flags.ovf, out_flags.neg, out_flags.zero,
                    out_flags.carry, out_result};

  // Reset leaves the status word clear
  a_flags_reset: assert property (@(posedge clk) rst |=> (flags == '0))
    else $error("status flags not cleared by reset");

  // Status word only moves when an item executes
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !exec_go |=> $stable(flags))
    else $error("status flags changed without an executing item");

  // Delivered flags match the kept status word
  a_out_flags: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> (out_flags == flags))
    else $error("result flags differ from status register");

  // Empty input stage always takes a transfer
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled while input stage empty");

endmodule

@@ design/toaluf_exec.sv @@
// Combinational execute logic: result word and next status flags for one item.
module toaluf_exec (
  input  toaluf_pkg::item_t  item,
  input  toaluf_pkg::flags_t flags,
  output logic [15:0]        result_value,
  output toaluf_pkg::flags_t flags_next
);

  logic [16:0] word_sum;
  logic [8:0]  byte_sum;
  logic [15:0] nsrc;
  logic [15:0] word_diff;
  logic [7:0]  byte_diff;
  logic [15:0] logic_res;
  logic [15:0] arith_res;   // value the sign/zero flags look at
  logic [15:0] sign_src;    // source seen by the carry/overflow tables
  logic [15:0] bit_mask;
  logic [15:0] test_and;
  logic        in_range;
  logic        s_sign;
  logic        d_sign;
  logic        r_sign;
  logic [2:0]  tab_idx;
  logic        z_arith;
  logic        byte_op;

  assign byte_op   = item.byte_mode;
  assign nsrc      = ~item.source_value;
  assign word_sum  = {1'b0, item.dest_value} + {1'b0, item.source_value}
                     + {16'd0, item.carry_in};
  assign byte_sum  = {1'b0, item.dest_value[7:0]} + {1'b0, item.source_value[7:0]}
                     + {8'd0, item.carry_in};
  assign word_diff = item.dest_value + nsrc + 16'd1;
  assign byte_diff = item.dest_value[7:0] + nsrc[7:0] + 8'd1;
  assign test_and  = item.dest_value & item.source_value;
  assign in_range  = (item.source_value[15:4] == 12'd0);
  assign bit_mask  = in_range ? (16'd1 << item.source_value[3:0]) : 16'd0;

  // Operation result before the byte-mode merge
  always_comb begin
    unique case (item.cmd)
      toaluf_pkg::OP_XOR: logic_res = item.dest_value ^ item.source_value;
      toaluf_pkg::OP_AND: logic_res = item.dest_value & item.source_value;
      toaluf_pkg::OP_OR:  logic_res = item.dest_value | item.source_value;
      toaluf_pkg::OP_ADD: logic_res = byte_op ? {8'd0, byte_sum[7:0]} : word_sum[15:0];
      toaluf_pkg::OP_CMP: logic_res = byte_op ? {8'd0, byte_diff} : word_diff;
      default:            logic_res = item.dest_value;
    endcase
  end

  // Byte mode keeps the high byte of dest
  assign arith_res = byte_op
                     ? ((item.dest_value & toaluf_pkg::HIGH_BYTE_MASK)
                        | (logic_res & toaluf_pkg::LOW_BYTE_MASK))
                     : logic_res;
  assign sign_src  = (item.cmd == toaluf_pkg::OP_CMP) ? nsrc : item.source_value;

  assign s_sign  = byte_op ? sign_src[7] : sign_src[15];
  assign d_sign  = byte_op ? item.dest_value[7] : item.dest_value[15];
  assign r_sign  = byte_op ? arith_res[7] : arith_res[15];
  assign tab_idx = {s_sign, d_sign, r_sign};
  assign z_arith = byte_op ? (arith_res[7:0] == 8'd0) : (arith_res == 16'd0);

  always_comb begin
    flags_next   = flags;
    result_value = item.dest_value;
    unique case (item.cmd)
      toaluf_pkg::OP_ADD, toaluf_pkg::OP_XOR, toaluf_pkg::OP_AND,
      toaluf_pkg::OP_OR, toaluf_pkg::OP_CMP: begin
        if (item.cmd != toaluf_pkg::OP_CMP) begin
          result_value = arith_res;
        end
        flags_next.carry = toaluf_pkg::CARRY_TAB[tab_idx];
        flags_next.ovf   = toaluf_pkg::OVF_TAB[tab_idx];
        flags_next.neg   = r_sign;
        flags_next.zero  = z_arith;
      end
      toaluf_pkg::OP_BIT: begin
        if (test_and != 16'd0) begin
          flags_next.zero = 1'b0;
          flags_next.neg  = byte_op ? test_and[7] : test_and[15];
        end else begin
          flags_next.zero = 1'b1;
        end
      end
      toaluf_pkg::OP_BIS: begin
        result_value    = item.dest_value | bit_mask;
        flags_next.zero = 1'b0;
      end
      toaluf_pkg::OP_BIC: begin
        result_value    = item.dest_value & ~bit_mask;
        flags_next.zero = ((item.dest_value & ~bit_mask) == 16'd0);
      end
      default: begin
        result_value = item.dest_value;
      end
    endcase
  end

endmodule
